// ===== src/sstf_pkg.sv =====
// Shared constants, types and codes for the shortest-seek-first disk scheduler.
package sstf_pkg;

  // Default sizing handed to the top level
  localparam int DEF_MAX_REQUESTS = 32;
  localparam int DEF_TRACK_BITS   = 12;

  // Fixed field widths on the ports
  localparam int FIELD_TRACK_W = 12;
  localparam int SUM_W         = 17;
  localparam int AVG_W         = 12;
  localparam int WIDE_TRACK_W  = 16;

  // Stream packing
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_SUM_LSB = FIELD_TRACK_W;
  localparam int OUT_AVG_LSB = FIELD_TRACK_W + SUM_W;
  localparam int OUT_PAD_W   = OUT_TDATA_W - FIELD_TRACK_W - SUM_W - AVG_W;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] REG_START_HEAD_ADDR = 3'd0;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_COMMIT,
    ST_EMIT,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT_LAST
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic store;
    logic init;
    logic scan_clear;
    logic scan_run;
    logic commit;
    logic div_start;
    logic emit;
    logic emit_last;
    logic emit_avg;
    logic clear_batch;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;
    logic count_zero;
    logic final_serve;
    logic scan_done;
    logic div_done;
  } dp_status_t;

endpackage

// ===== src/sstf_div.sv =====
// Restoring divider, one quotient bit per cycle.
module sstf_div #(
  parameter int DIVIDEND_W = 17,
  parameter int DIVISOR_W  = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic                  done
);

  localparam int StepW = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  rem;
  logic [StepW-1:0]      step;
  logic                  busy;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  // Shift the next dividend bit into the partial remainder and try a subtract
  assign trial = {rem, quo[DIVIDEND_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= StepW'(DIVIDEND_W);
      end else if (busy) begin
        step <= step - StepW'(1);
        if (step == StepW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Advance remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo <= {quo[DIVIDEND_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

// ===== src/sstf_dpath.sv =====
// Datapath: request store, nearest-track scan, movement sum and result register.
module sstf_dpath #(
  parameter int MAX_REQUESTS = sstf_pkg::DEF_MAX_REQUESTS,
  parameter int TRACK_BITS   = sstf_pkg::DEF_TRACK_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sstf_pkg::dp_cmd_t                   cmd,
  output sstf_pkg::dp_status_t                status,
  input  logic [sstf_pkg::FIELD_TRACK_W-1:0]  request_track,
  input  logic [sstf_pkg::FIELD_TRACK_W-1:0]  start_head,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sstf_pkg::FIELD_TRACK_W-1:0]  served_track,
  output logic [sstf_pkg::SUM_W-1:0]          total_movement,
  output logic [sstf_pkg::AVG_W-1:0]          average_seek,
  output logic                                last_result
);

  localparam int CntW  = $clog2(MAX_REQUESTS + 1);
  localparam int IdxW  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int DivW  = $clog2(MAX_REQUESTS + 2);
  localparam int WideW = sstf_pkg::WIDE_TRACK_W;
  localparam int SumW  = sstf_pkg::SUM_W;
  localparam int TrkW  = sstf_pkg::FIELD_TRACK_W;
  localparam int AvgW  = sstf_pkg::AVG_W;

  logic [TRACK_BITS-1:0]   mem [MAX_REQUESTS];
  logic [TRACK_BITS-1:0]   rd_data;
  logic [CntW-1:0]         count;
  logic [MAX_REQUESTS-1:0] served;
  logic [TRACK_BITS-1:0]   head;
  logic [SumW-1:0]         sum;
  logic [CntW-1:0]         served_cnt;
  logic [CntW-1:0]         issue_cnt;
  logic                    cmp_valid;
  logic [IdxW-1:0]         cmp_idx;
  logic                    found;
  logic [IdxW-1:0]         best_idx;
  logic [TRACK_BITS-1:0]   best_d;
  logic [TRACK_BITS-1:0]   best_trk;

  logic [WideW-1:0]        req_wide;
  logic [WideW-1:0]        start_wide;
  logic [WideW-1:0]        head_wide;
  logic [TRACK_BITS-1:0]   req_trk;
  logic [TRACK_BITS-1:0]   start_trk;
  logic                    wr_en;
  logic [IdxW-1:0]         rd_idx;
  logic                    issue_go;
  logic [TRACK_BITS-1:0]   cand_d;
  logic                    cand_better;
  logic [DivW-1:0]         divisor;
  logic [SumW-1:0]         quotient;
  logic                    div_done;

  // Take tracks modulo the track width
  assign req_wide   = WideW'(request_track);
  assign start_wide = WideW'(start_head);
  assign head_wide  = WideW'(head);
  assign req_trk    = req_wide[TRACK_BITS-1:0];
  assign start_trk  = start_wide[TRACK_BITS-1:0];

  // Request store: one write port for loading, one registered read for the scan
  assign wr_en  = cmd.store && (count < CntW'(MAX_REQUESTS));
  assign rd_idx = issue_cnt[IdxW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[IdxW-1:0]] <= req_trk;
    end
    rd_data <= mem[rd_idx];
  end

  // Batch control state: fill count, served flags, head and movement
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      served     <= '0;
      head       <= '0;
      sum        <= '0;
      served_cnt <= '0;
    end else begin
      if (wr_en) begin
        count <= count + CntW'(1);
      end
      if (cmd.init) begin
        head       <= start_trk;
        sum        <= '0;
        served_cnt <= '0;
      end
      if (cmd.commit) begin
        served[best_idx] <= 1'b1;
        sum              <= sum + SumW'(best_d);
        head             <= best_trk;
        served_cnt       <= served_cnt + CntW'(1);
      end
      if (cmd.clear_batch) begin
        count  <= '0;
        served <= '0;
      end
    end
  end

  // Scan: issue one read per cycle and compare each entry as it returns from the registered read
  assign issue_go = cmd.scan_run && (issue_cnt != count);
  assign cand_d   = (rd_data > head) ? (rd_data - head) : (head - rd_data);
  assign cand_better = !served[cmp_idx] &&
                       (!found || (cand_d < best_d) ||
                        ((cand_d == best_d) && (rd_data < best_trk)));

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
      issue_cnt <= '0;
      found     <= 1'b0;
    end else begin
      cmp_valid <= issue_go;
      if (cmd.scan_clear) begin
        issue_cnt <= '0;
        found     <= 1'b0;
      end else begin
        if (issue_go) begin
          issue_cnt <= issue_cnt + CntW'(1);
        end
        if (cmp_valid && cand_better) begin
          found <= 1'b1;
        end
      end
    end
  end

  // Hold the best candidate so far
  always_ff @(posedge clk) begin
    if (issue_go) begin
      cmp_idx <= rd_idx;
    end
    if (cmp_valid && cand_better) begin
      best_idx <= cmp_idx;
      best_d   <= cand_d;
      best_trk <= rd_data;
    end
  end

  // Average seek over visited positions
  assign divisor = DivW'(count) + DivW'(1);

  sstf_div #(
    .DIVIDEND_W (SumW),
    .DIVISOR_W  (DivW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum),
    .divisor  (divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  // Result register: parts the scan from the downstream stall
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      served_track   <= head_wide[TrkW-1:0];
      total_movement <= sum;
      average_seek   <= cmd.emit_avg ? quotient[AvgW-1:0] : '0;
      last_result    <= cmd.emit_last;
    end
  end

  // Report to the controller
  always_comb begin
    status.out_free    = !out_valid || out_ready;
    status.count_zero  = (count == '0);
    status.final_serve = ((served_cnt + CntW'(1)) == count);
    status.scan_done   = (issue_cnt == count) && !cmp_valid;
    status.div_done    = div_done;
  end

endmodule

// ===== src/sstf_ctrl.sv =====
// Controller: sequences loading, scans, commits, averaging and result transfers.
module sstf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_last,
  output logic                 in_ready,
  input  sstf_pkg::dp_status_t status,
  output sstf_pkg::dp_cmd_t    cmd
);

  sstf_pkg::state_t state;
  sstf_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sstf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      sstf_pkg::ST_IDLE: begin
        if (in_valid && in_last) state_next = sstf_pkg::ST_START;
      end
      sstf_pkg::ST_START: begin
        if (status.out_free) begin
          state_next = status.count_zero ? sstf_pkg::ST_IDLE : sstf_pkg::ST_SCAN;
        end
      end
      sstf_pkg::ST_SCAN: begin
        if (status.scan_done) state_next = sstf_pkg::ST_COMMIT;
      end
      sstf_pkg::ST_COMMIT: begin
        state_next = status.final_serve ? sstf_pkg::ST_DIV_START : sstf_pkg::ST_EMIT;
      end
      sstf_pkg::ST_EMIT: begin
        if (status.out_free) state_next = sstf_pkg::ST_SCAN;
      end
      sstf_pkg::ST_DIV_START: begin
        state_next = sstf_pkg::ST_DIV_WAIT;
      end
      sstf_pkg::ST_DIV_WAIT: begin
        if (status.div_done) state_next = sstf_pkg::ST_EMIT_LAST;
      end
      sstf_pkg::ST_EMIT_LAST: begin
        if (status.out_free) state_next = sstf_pkg::ST_IDLE;
      end
      default: state_next = sstf_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      sstf_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.store = in_valid;
        cmd.init  = in_valid && in_last;
      end
      sstf_pkg::ST_START: begin
        if (status.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_last   = status.count_zero;
          cmd.clear_batch = status.count_zero;
          cmd.scan_clear  = 1'b1;
        end
      end
      sstf_pkg::ST_SCAN: begin
        cmd.scan_run = 1'b1;
      end
      sstf_pkg::ST_COMMIT: begin
        cmd.commit = 1'b1;
      end
      sstf_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit       = 1'b1;
          cmd.scan_clear = 1'b1;
        end
      end
      sstf_pkg::ST_DIV_START: begin
        cmd.div_start = 1'b1;
      end
      sstf_pkg::ST_DIV_WAIT: begin
        cmd = '0;
      end
      sstf_pkg::ST_EMIT_LAST: begin
        if (status.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_last   = 1'b1;
          cmd.emit_avg    = 1'b1;
          cmd.clear_batch = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== src/sstf_disk_scheduler.sv =====
// Top level of the shortest-seek-first disk scheduler: config register and stream ports.
//
// Requests are loaded one per cycle into a store of MAX_REQUESTS entries; a transfer
// with tlast set starts scheduling from the start_head register. The block then emits
// the start head and, for each of the n stored requests, the nearest unserved track
// with the running head movement. Each served request costs a scan of the store
// through its single read port, and the final result also waits for the bit-serial
// average divider. Input is refused from the last request of a batch until the final
// result has been placed in the output register; that result may then wait while a
// new batch loads.
module sstf_disk_scheduler #(
  parameter int MAX_REQUESTS = sstf_pkg::DEF_MAX_REQUESTS,
  parameter int TRACK_BITS   = sstf_pkg::DEF_TRACK_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sstf_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [sstf_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [sstf_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  // Request stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [sstf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [11:0] request_track
  input  logic                               s_axis_tlast,   // last_request
  // Result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [sstf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // [11:0] served_track,
                                                             // [28:12] total_movement,
                                                             // [40:29] average_seek
  output logic                               m_axis_tlast    // last_result
);

  localparam int TrkW = sstf_pkg::FIELD_TRACK_W;

  logic [TrkW-1:0]               start_head;
  logic                          reg_hit;
  sstf_pkg::dp_cmd_t             cmd;
  sstf_pkg::dp_status_t          status;
  logic [TrkW-1:0]               served_track;
  logic [sstf_pkg::SUM_W-1:0]    total_movement;
  logic [sstf_pkg::AVG_W-1:0]    average_seek;
  logic                          last_result;

  // Register decode
  assign reg_hit = (paddr == sstf_pkg::REG_START_HEAD_ADDR);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_head <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      start_head <= pwdata[TrkW-1:0];
    end
  end

  assign prdata = reg_hit ? sstf_pkg::APB_DATA_W'(start_head) : '0;

  sstf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sstf_dpath #(
    .MAX_REQUESTS (MAX_REQUESTS),
    .TRACK_BITS   (TRACK_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .request_track  (s_axis_tdata[TrkW-1:0]),
    .start_head     (start_head),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .served_track   (served_track),
    .total_movement (total_movement),
    .average_seek   (average_seek),
    .last_result    (last_result)
  );

  // Pack the result transfer
  assign m_axis_tdata = {{sstf_pkg::OUT_PAD_W{1'b0}}, average_seek, total_movement,
                         served_track};
  assign m_axis_tlast = last_result;

endmodule

// ===== src/sstf_checker.sv =====
// Port-level checks for the disk scheduler, bound to the top level.
module sstf_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             s_axis_tlast,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [sstf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tlast
);

  localparam int AvgLsb = sstf_pkg::OUT_AVG_LSB;
  localparam int AvgMsb = sstf_pkg::OUT_AVG_LSB + sstf_pkg::AVG_W - 1;

  // Close the input once a batch is complete
  a_batch_closes: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("request accepted right after the last request of a batch");

  // Hold a stalled result
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled result changed or dropped");

  // Average only on the final result
  a_avg_on_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[AvgMsb:AvgLsb] == '0))
    else $error("average seek set on a result that is not final");

  // Drop results on reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind sstf_disk_scheduler sstf_checker u_checker (.*);

// ===== bench/sstf_disk_scheduler_tb.sv =====
// Testbench for the shortest-seek-first disk scheduler: scoreboard and stream/APB drivers.
module sstf_disk_scheduler_tb;

  localparam int MAX_REQ       = sstf_pkg::DEF_MAX_REQUESTS;
  localparam int RANDOM_ITEMS  = 385;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int IDLE_PCT      = 23;
  localparam int TRACK_TOP     = (1 << sstf_pkg::FIELD_TRACK_W) - 1;
  localparam int PRINT_CAP     = 100;
  // Second word of the register map; nothing lives there
  localparam logic [sstf_pkg::APB_ADDR_W-1:0] SPARE_REG_ADDR = 3'd4;

  typedef logic [sstf_pkg::FIELD_TRACK_W-1:0] track_t;
  typedef track_t track_q_t[$];

  typedef struct packed {
    track_t                     track;
    logic [sstf_pkg::SUM_W-1:0] total;
    logic [sstf_pkg::AVG_W-1:0] avg;
    logic                       last;
  } visit_t;

  typedef enum int {SPREAD_UNIFORM, SPREAD_CLUSTER, SPREAD_EDGES} spread_t;

  // Predicts the head visits of each batch and checks them in order
  class seek_scoreboard;
    track_t start_head;
    track_t loaded[$];
    visit_t expected_visits[$];
    int     errors;

    function new();
      start_head = '0;
      errors     = 0;
    endfunction

    function void report(string what);
      errors++;
      if (errors <= PRINT_CAP) $display("mismatch: %s", what);
    endfunction

    function void write_reg(logic [sstf_pkg::APB_ADDR_W-1:0] addr,
                            logic [sstf_pkg::APB_DATA_W-1:0] value);
      if (addr == sstf_pkg::REG_START_HEAD_ADDR)
        start_head = value[sstf_pkg::FIELD_TRACK_W-1:0];
    endfunction

    // Store the request unless the store is full; a last request schedules the batch
    function void note_request(track_t track, logic last);
      if (loaded.size() < MAX_REQ) loaded.push_back(track);
      if (last) begin
        plan_visits();
        loaded.delete();
      end
    endfunction

    // Nearest unserved track first; equal distance goes to the smaller track
    function void plan_visits();
      bit                         done[MAX_REQ];
      visit_t                     v;
      track_t                     head;
      logic [sstf_pkg::SUM_W-1:0] sum;
      int                         n, best, best_d, d, q;
      n = loaded.size();
      foreach (done[i]) done[i] = 1'b0;
      head    = start_head;
      sum     = '0;
      v.track = head;
      v.total = '0;
      v.avg   = '0;
      v.last  = (n == 0);
      expected_visits.push_back(v);
      for (int k = 0; k < n; k++) begin
        best   = -1;
        best_d = 0;
        for (int i = 0; i < n; i++) begin
          if (done[i]) continue;
          d = int'(loaded[i]) - int'(head);
          if (d < 0) d = -d;
          if (best < 0 || d < best_d || (d == best_d && loaded[i] < loaded[best])) begin
            best   = i;
            best_d = d;
          end
        end
        done[best] = 1'b1;
        sum        = sum + best_d[sstf_pkg::SUM_W-1:0];
        head       = loaded[best];
        v.track    = head;
        v.total    = sum;
        v.last     = (k == n - 1);
        q          = int'(sum) / (n + 1);
        v.avg      = v.last ? q[sstf_pkg::AVG_W-1:0] : '0;
        expected_visits.push_back(v);
      end
    endfunction

    function void check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endfunction

    function void check_visit(logic [sstf_pkg::OUT_TDATA_W-1:0] tdata, logic tlast);
      visit_t want;
      if (expected_visits.size() == 0) begin
        report($sformatf("result %h with nothing expected", tdata));
        return;
      end
      want = expected_visits.pop_front();
      check_field("served_track", 32'(tdata[sstf_pkg::FIELD_TRACK_W-1:0]),
                  32'(want.track));
      check_field("total_movement",
                  32'(tdata[sstf_pkg::OUT_SUM_LSB +: sstf_pkg::SUM_W]), 32'(want.total));
      check_field("average_seek",
                  32'(tdata[sstf_pkg::OUT_AVG_LSB +: sstf_pkg::AVG_W]), 32'(want.avg));
      check_field("last_result", 32'(tlast), 32'(want.last));
    endfunction

    function int pending();
      return expected_visits.size();
    endfunction
  endclass

  logic                              clk;
  logic                              rst;
  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic [sstf_pkg::APB_ADDR_W-1:0]   paddr;
  logic [sstf_pkg::APB_DATA_W-1:0]   pwdata;
  logic [sstf_pkg::APB_DATA_W-1:0]   prdata;
  logic                              pready;
  logic                              s_axis_tvalid;
  logic                              s_axis_tready;
  logic [sstf_pkg::IN_TDATA_W-1:0]   s_axis_tdata;   // [11:0] request_track
  logic                              s_axis_tlast;   // last_request
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [sstf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;   // [11:0] served_track,
                                                     // [28:12] total_movement,
                                                     // [40:29] average_seek
  logic                              m_axis_tlast;   // last_result

  seek_scoreboard sb;
  bit             idling;
  int             items_sent;
  int             cycle_count;

  sstf_disk_scheduler dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abandon a run that hangs
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // Check each result transfer and stall the result side at random
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_visit(m_axis_tdata, m_axis_tlast);
      m_axis_tready <= !idling || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Present one request and hold it until the transfer
  task automatic send_request(track_t track, logic last);
    while (idling && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(sstf_pkg::IN_TDATA_W - sstf_pkg::FIELD_TRACK_W){1'b0}}, track};
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_request(track, last);
    items_sent++;
  endtask

  task automatic send_batch(track_q_t tracks);
    foreach (tracks[i]) send_request(tracks[i], i == tracks.size() - 1);
  endtask

  // Drop the request valid and let every predicted visit arrive
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic [sstf_pkg::APB_ADDR_W-1:0] addr,
                           logic [sstf_pkg::APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(addr, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read_check(logic [sstf_pkg::APB_ADDR_W-1:0] addr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[sstf_pkg::FIELD_TRACK_W-1:0] !== sb.start_head)
      sb.report($sformatf("start_head read %h expected %h", prdata, sb.start_head));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_start_head(logic [sstf_pkg::APB_DATA_W-1:0] value);
    apb_write(sstf_pkg::REG_START_HEAD_ADDR, value);
    apb_read_check(sstf_pkg::REG_START_HEAD_ADDR);
  endtask

  function automatic track_t pick_track(spread_t spread, track_t centre);
    int t;
    case (spread)
      SPREAD_UNIFORM: t = $urandom_range(0, TRACK_TOP);
      SPREAD_CLUSTER: begin
        t = int'(centre) + int'($urandom_range(0, 16)) - 8;
        if (t < 0) t = 0;
        if (t > TRACK_TOP) t = TRACK_TOP;
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       t = 0;
          1:       t = TRACK_TOP;
          default: t = $urandom_range(0, TRACK_TOP);
        endcase
      end
    endcase
    return track_t'(t);
  endfunction

  // Mostly short batches, a few near or past the store size
  function automatic int pick_batch_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, MAX_REQ - 1);
    return $urandom_range(MAX_REQ, MAX_REQ + 4);
  endfunction

  initial begin
    track_q_t batch;
    int       size, r, batch_no, base;
    spread_t  spread;
    track_t   centre;
    sb            = new();
    idling        = 1'b1;
    items_sent    = 0;
    rst           <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Head at the top track, request at the bottom; upper write bits are ignored
    program_start_head(32'hFFFF_FFFF);
    batch = '{12'd0};
    send_batch(batch);
    wait_idle();

    // Equal distances either side of the head, duplicate tracks
    program_start_head(32'd100);
    batch = '{12'd110, 12'd90, 12'd110, 12'd90};
    send_batch(batch);
    wait_idle();

    // Write to the unused address must leave start_head alone
    apb_write(SPARE_REG_ADDR, 32'h0000_0ABC);
    apb_read_check(sstf_pkg::REG_START_HEAD_ADDR);
    batch = '{12'd4095, 12'd0, 12'd2048, 12'd7};
    send_batch(batch);
    wait_idle();

    program_start_head(32'd0);
    batch = '{12'd4095, 12'd4095, 12'd0, 12'd1, 12'd2730, 12'd1365};
    send_batch(batch);
    wait_idle();

    // Head sitting on a request: zero-length seek
    program_start_head(32'd2048);
    batch = '{12'hAAA, 12'h555, 12'hFFF, 12'h000, 12'h800};
    send_batch(batch);
    wait_idle();
    batch = '{12'd2048};
    send_batch(batch);

    // Random batches; the first two overfill the store and the requests beyond its size are dropped
    base     = items_sent;
    batch_no = 0;
    while (items_sent - base < RANDOM_ITEMS) begin
      idling = !((items_sent - base >= 140) && (items_sent - base < 280));
      if (batch_no == 0) size = MAX_REQ + 1;
      else if (batch_no == 1) size = MAX_REQ + 4;
      else size = pick_batch_size();
      spread = spread_t'($urandom_range(0, 2));
      centre = track_t'($urandom_range(0, TRACK_TOP));
      batch.delete();
      repeat (size) batch.push_back(pick_track(spread, centre));
      send_batch(batch);
      batch_no++;
      // Retune the start head between batches now and then
      if ($urandom_range(0, 99) < 30) begin
        wait_idle();
        r = $urandom_range(0, 99);
        if (r < 10) apb_write(SPARE_REG_ADDR, $urandom());
        else if (r < 25) program_start_head(32'd0);
        else if (r < 40) program_start_head(32'(TRACK_TOP));
        else if (r < 60) program_start_head(32'(centre));
        else program_start_head($urandom());
      end
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
